### rtl/hmm_pkg.sv
// ----------------------------------------------------------------------------
// hmm_pkg
// Shared types and constants of the histogram mean and median unit.
// ----------------------------------------------------------------------------
package hmm_pkg;

    localparam int MEAN_FRAC_W = 8;
    localparam int MEAN_W      = 20;
    localparam int MEDIAN_W    = 12;
    localparam int COUNT_W     = 31;
    localparam int IN_BIN_W    = 12;
    localparam int TOP_W       = 12;
    localparam int CCNT_W      = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int DIV_STEPS   = MEAN_W;

    localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

    localparam logic CFG_TOP_VALUE   = 1'b0;
    localparam logic CFG_COLOR_COUNT = 1'b1;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef struct packed {
        logic clear;
        logic load;
        logic begin_compute;
        logic walk_start;
        logic pass2;
        logic div_start;
        logic emit;
        logic next_color;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic walk_done;
        logic div_done;
        logic out_free;
        logic last_color;
    } sts_t;

endpackage

### rtl/histogram_mean_median_unit.sv
// ----------------------------------------------------------------------------
// histogram_mean_median_unit
// Per-colour histogram store with mean and median computation.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  s_*      | in  | tuser: action[0], color[2:1]; tdata: bin[11:0], count[42:12]
//  m_*      | out | tuser: result_color; tdata: mean[19:0], median[31:20],
//           |     | empty[32]; tlast: last colour
//  cfg_*    | in  | index 0 top_value, index 1 color_count
//
// After reset the store is swept to zero, one entry a cycle, over all
// COLOR_COUNT * 2**clog2(BIN_COUNT) entries (12288 by default); s_tready stays low.
// A compute makes per colour two walks over top_value+1 bins through the
// store's single read port, runs the bit-serial divider between them and then
// hands over the result.
// A stalled m_tready holds the next colour until its result register frees.
// ----------------------------------------------------------------------------
module histogram_mean_median_unit
    import hmm_pkg::*;
#(
    parameter int BIN_COUNT   = 4096,
    parameter int COLOR_COUNT = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2:0]            s_tuser,   // action, color
    input  logic [47:0]           s_tdata,   // bin, count, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [1:0]            m_tuser,   // result_color
    output logic [39:0]           m_tdata,   // mean_fixed, median_bin, empty_res, pad
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t                cmd;
    sts_t                sts;
    logic [MEAN_W-1:0]   mean;
    logic [MEDIAN_W-1:0] median;
    logic                empty;

    hmm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_action (s_tuser[0]),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hmm_dpath #(
        .BIN_COUNT   (BIN_COUNT),
        .COLOR_COUNT (COLOR_COUNT)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_color   (s_tuser[2:1]),
        .in_bin     (s_tdata[11:0]),
        .in_count   (s_tdata[42:12]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_color  (m_tuser),
        .out_mean   (mean),
        .out_median (median),
        .out_empty  (empty),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'd0, empty, median, mean};

endmodule

### rtl/hmm_ctrl.sv
// ----------------------------------------------------------------------------
// hmm_ctrl
// Sequencer: clearing sweep, load handling and the per-colour compute passes.
// ----------------------------------------------------------------------------
module hmm_ctrl
    import hmm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_action,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_P1    = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_P2    = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire && in_action == ACT_LOAD)
                begin
                    cmd.load = 1'b1;
                end
                if (in_fire && in_action == ACT_COMPUTE)
                begin
                    cmd.begin_compute = 1'b1;
                    cmd.walk_start    = 1'b1;
                    state_next        = ST_P1;
                end
            end
            ST_P1:
            begin
                if (sts.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.pass2      = 1'b1;
                    state_next     = ST_P2;
                end
            end
            ST_P2:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_color)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_color = 1'b1;
                        cmd.walk_start = 1'b1;
                        state_next     = ST_P1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/hmm_dpath.sv
// ----------------------------------------------------------------------------
// hmm_dpath
// Histogram store, bin walk pipeline, accumulators, divider and output stage.
// ----------------------------------------------------------------------------
module hmm_dpath
    import hmm_pkg::*;
#(
    parameter int BIN_COUNT   = 4096,
    parameter int COLOR_COUNT = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [1:0]            in_color,
    input  logic [IN_BIN_W-1:0]   in_bin,
    input  logic [COUNT_W-1:0]    in_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_color,
    output logic [MEAN_W-1:0]     out_mean,
    output logic [MEDIAN_W-1:0]   out_median,
    output logic                  out_empty,
    output logic                  out_last
);

    localparam int BIN_W   = $clog2(BIN_COUNT);
    localparam int COL_W   = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;
    localparam int AW      = COL_W + BIN_W;
    localparam int DEPTH   = COLOR_COUNT * (2 ** BIN_W);
    localparam int TOT_W   = COUNT_W + BIN_W;
    localparam int WS_W    = COUNT_W + 2 * BIN_W;
    localparam int PROD_W  = COUNT_W + BIN_W;
    localparam int DV_W    = WS_W + DIV_STEPS + BIN_W;
    localparam int CMP_W   = 18;

    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [BIN_W-1:0] TOP_MAX   = BIN_W'(BIN_COUNT - 1);

    logic [COUNT_W-1:0] mem [DEPTH];

    logic [TOP_W-1:0]   top_reg;
    logic [CCNT_W-1:0]  ccnt_reg;
    logic [BIN_W-1:0]   top_eff;
    logic [2:0]         colors_eff;

    logic [AW-1:0]      clr_reg;
    logic [COL_W-1:0]   col_reg;
    logic               pass2_reg;
    logic               active_reg;
    logic               issue_reg;
    logic [BIN_W-1:0]   widx_reg;
    logic               v1_reg;
    logic [BIN_W-1:0]   idx1_reg;
    logic [COUNT_W-1:0] rd_reg;
    logic               v2_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [COUNT_W-1:0] n2_reg;

    logic [TOT_W-1:0]   total_reg;
    logic [WS_W-1:0]    wsum_reg;
    logic [TOT_W-1:0]   run_reg;
    logic [TOT_W-1:0]   run_next;
    logic               found_reg;
    logic [BIN_W-1:0]   med_reg;

    logic [DV_W-1:0]    rem_reg;
    logic [DV_W-1:0]    dsr_reg;
    logic [MEAN_W-1:0]  quot_reg;
    logic [4:0]         step_reg;
    logic               div_busy_reg;
    logic               sat_reg;
    logic               empty_reg;

    logic               load_ok;
    logic [AW-1:0]      load_addr;
    logic [AW-1:0]      rd_addr;

    // effective configuration
    always_comb
    begin
        if (CMP_W'(top_reg) >= CMP_W'(BIN_COUNT))
        begin
            top_eff = TOP_MAX;
        end
        else
        begin
            top_eff = BIN_W'(top_reg);
        end
        if (ccnt_reg == '0)
        begin
            colors_eff = 3'd1;
        end
        else if (3'(ccnt_reg) > 3'(COLOR_COUNT))
        begin
            colors_eff = 3'(COLOR_COUNT);
        end
        else
        begin
            colors_eff = 3'(ccnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= '1;
            ccnt_reg <= 2'd3;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TOP_VALUE)
            begin
                top_reg <= cfg_data[TOP_W-1:0];
            end
            else
            begin
                ccnt_reg <= cfg_data[CCNT_W-1:0];
            end
        end
    end

    // histogram store
    assign load_ok   = cmd.load && (3'(in_color) < 3'(COLOR_COUNT))
                       && (CMP_W'(in_bin) < CMP_W'(BIN_COUNT));
    assign load_addr = {COL_W'(in_color), BIN_W'(in_bin)};
    assign rd_addr   = {col_reg, widx_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_reg] <= '0;
        end
        else if (load_ok)
        begin
            mem[load_addr] <= in_count;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    assign sts.clear_done = cmd.clear && (clr_reg == LAST_ADDR);

    // bin walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            pass2_reg  <= 1'b0;
            active_reg <= 1'b0;
            issue_reg  <= 1'b0;
            widx_reg   <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.begin_compute)
            begin
                col_reg <= '0;
            end
            else if (cmd.next_color)
            begin
                col_reg <= col_reg + COL_W'(1);
            end
            if (cmd.walk_start)
            begin
                pass2_reg  <= cmd.pass2;
                active_reg <= 1'b1;
                issue_reg  <= 1'b1;
                widx_reg   <= '0;
            end
            else
            begin
                if (issue_reg)
                begin
                    if (widx_reg == top_eff)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        widx_reg <= widx_reg + BIN_W'(1);
                    end
                end
                if (sts.walk_done)
                begin
                    active_reg <= 1'b0;
                end
            end
            v1_reg <= issue_reg && !cmd.walk_start;
            v2_reg <= v1_reg;
        end
    end

    assign sts.walk_done = active_reg && !issue_reg && !v1_reg && !v2_reg;

    // accumulators
    assign run_next = run_reg + TOT_W'(rd_reg);

    always_ff @(posedge clk)
    begin
        idx1_reg <= widx_reg;
        prod_reg <= PROD_W'(rd_reg) * PROD_W'(idx1_reg);
        n2_reg   <= rd_reg;
        if (cmd.walk_start && !cmd.pass2)
        begin
            total_reg <= '0;
            wsum_reg  <= '0;
        end
        else if (v2_reg && !pass2_reg)
        begin
            total_reg <= total_reg + TOT_W'(n2_reg);
            wsum_reg  <= wsum_reg + WS_W'(prod_reg);
        end
        if (cmd.walk_start)
        begin
            run_reg   <= '0;
            found_reg <= 1'b0;
            med_reg   <= '0;
        end
        else if (v1_reg && pass2_reg && !found_reg)
        begin
            run_reg <= run_next;
            if (run_next >= (total_reg >> 1))
            begin
                found_reg <= 1'b1;
                med_reg   <= idx1_reg;
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            step_reg     <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            step_reg     <= 5'(DIV_STEPS);
        end
        else if (div_busy_reg)
        begin
            step_reg <= step_reg - 5'd1;
            if (step_reg == 5'd1)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    assign sts.div_done = div_busy_reg && (step_reg == 5'd1);

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg   <= DV_W'(wsum_reg) << MEAN_FRAC_W;
            dsr_reg   <= DV_W'(total_reg) << (DIV_STEPS - 1);
            quot_reg  <= '0;
            empty_reg <= (total_reg == '0);
            sat_reg   <= DV_W'(wsum_reg) >= (DV_W'(total_reg) << (MEAN_W - MEAN_FRAC_W));
        end
        else if (div_busy_reg)
        begin
            dsr_reg <= dsr_reg >> 1;
            if (rem_reg >= dsr_reg)
            begin
                rem_reg  <= rem_reg - dsr_reg;
                quot_reg <= {quot_reg[MEAN_W-2:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[MEAN_W-2:0], 1'b0};
            end
        end
    end

    // output register
    assign sts.out_free   = !out_valid || out_ready;
    assign sts.last_color = ((3'(col_reg) + 3'd1) == colors_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_color  <= 2'(col_reg);
            out_median <= MEDIAN_W'(med_reg);
            out_empty  <= empty_reg;
            out_last   <= sts.last_color;
            priority if (empty_reg)
            begin
                out_mean <= '0;
            end
            else if (sat_reg)
            begin
                out_mean <= MEAN_MAX;
            end
            else
            begin
                out_mean <= quot_reg;
            end
        end
    end

endmodule
